/* rtl/usqt_pkg.sv */
// Shared types, constants and helper functions of the UV sphere quad tessellator.
// Used by every module of the block; depends on nothing.
package usqt_pkg;

  localparam int MaxSlices      = 256;
  localparam int SliceW         = 9;
  localparam int CellW          = 8;
  localparam int FracBits       = 14;
  localparam int PosW           = 16;
  localparam int TexW           = 15;
  localparam int PhaseW         = 32;
  localparam int DivSteps       = 32;
  localparam int DivPerStage    = 8;
  localparam int DivStages      = DivSteps / DivPerStage;
  localparam int CordicSteps    = 20;
  localparam int CordicPerStage = 2;
  localparam int CordicStages   = CordicSteps / CordicPerStage;
  localparam int AngW           = 33;
  localparam int ProdW          = 2 * AngW;
  localparam int CfgIdxW        = 2;
  localparam int VtxCntW        = 3;
  localparam int InDataW        = 16;
  localparam int OutDataW       = 128;

  localparam logic [TexW-1:0]          TexOne      = TexW'(1 << FracBits);
  localparam logic [30:0]              HalfPiQ30   = 31'h6487ED51;
  localparam logic signed [AngW-1:0]   CordicStart = 33'sh26DD3B6A;
  localparam logic [VtxCntW-1:0]       LastVtx     = 3'd5;
  localparam logic [SliceW-1:0]        SliceReset  = 9'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_SLICES = 2'd0,
    CFG_Y_SLICES = 2'd1,
    CFG_INVERT   = 2'd2
  } cfg_idx_e;

  // One vertex request: corner indices, effective slice counts, flags.
  typedef struct packed {
    logic [SliceW-1:0] p;
    logic [SliceW-1:0] q;
    logic [SliceW-1:0] nx;
    logic [SliceW-1:0] ny;
    logic              neg;
    logic              last;
  } vreq_t;

  typedef struct packed {
    logic [TexW-1:0] tex_u;
    logic [TexW-1:0] tex_v;
    logic            neg;
    logic            last;
  } side_t;

  typedef struct packed {
    logic [PhaseW-1:0] pha;
    logic [PhaseW-1:0] phb;
    side_t             side;
  } phase_t;

  typedef struct packed {
    logic signed [AngW-1:0] sa;
    logic signed [AngW-1:0] ca;
    logic signed [AngW-1:0] sb;
    logic signed [AngW-1:0] cb;
    side_t                  side;
  } trig_t;

  function automatic logic signed [AngW-1:0] atan_q30(int k);
    case (k)
      0:       atan_q30 = 33'sh3243F6A8;
      1:       atan_q30 = 33'sh1DAC6705;
      2:       atan_q30 = 33'sh0FADBAFC;
      3:       atan_q30 = 33'sh07F56EA6;
      4:       atan_q30 = 33'sh03FEAB76;
      5:       atan_q30 = 33'sh01FFD55B;
      6:       atan_q30 = 33'sh00FFFAAA;
      7:       atan_q30 = 33'sh007FFF55;
      8:       atan_q30 = 33'sh003FFFEA;
      9:       atan_q30 = 33'sh001FFFFD;
      10:      atan_q30 = 33'sh000FFFFF;
      11:      atan_q30 = 33'sh0007FFFF;
      12:      atan_q30 = 33'sh0003FFFF;
      13:      atan_q30 = 33'sh0001FFFF;
      14:      atan_q30 = 33'sh0000FFFF;
      15:      atan_q30 = 33'sh00007FFF;
      16:      atan_q30 = 33'sh00003FFF;
      17:      atan_q30 = 33'sh00001FFF;
      18:      atan_q30 = 33'sh00000FFF;
      19:      atan_q30 = 33'sh000007FF;
      default: atan_q30 = '0;
    endcase
  endfunction

  // Corner code: bit 0 steps one longitude, bit 1 one latitude.
  function automatic logic [1:0] corner_code(logic neg, logic [VtxCntW-1:0] k);
    logic [1:0] c;
    c = 2'd0;
    if (!neg) begin
      case (k)
        3'd0:    c = 2'd0;
        3'd1:    c = 2'd2;
        3'd2:    c = 2'd1;
        3'd3:    c = 2'd2;
        3'd4:    c = 2'd3;
        3'd5:    c = 2'd1;
        default: c = 2'd0;
      endcase
    end else begin
      case (k)
        3'd0:    c = 2'd0;
        3'd1:    c = 2'd1;
        3'd2:    c = 2'd2;
        3'd3:    c = 2'd2;
        3'd4:    c = 2'd1;
        3'd5:    c = 2'd3;
        default: c = 2'd0;
      endcase
    end
    return c;
  endfunction

  // A count of zero acts as one, counts above the maximum act as the maximum.
  function automatic logic [SliceW-1:0] eff_slices(logic [SliceW-1:0] v);
    if (v == '0) begin
      return SliceW'(1);
    end else if (v > SliceW'(MaxSlices)) begin
      return SliceW'(MaxSlices);
    end
    return v;
  endfunction

endpackage

/* rtl/usqt_seq.sv */
// Vertex sequencer: holds one cell and issues its six corner requests.
// Depends on usqt_pkg.
module usqt_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     cell_valid_i,
  output logic                     cell_ready_o,
  input  logic [usqt_pkg::CellW-1:0]  cell_lon_i,
  input  logic [usqt_pkg::CellW-1:0]  cell_lat_i,
  input  logic [usqt_pkg::SliceW-1:0] x_slices_i,
  input  logic [usqt_pkg::SliceW-1:0] y_slices_i,
  input  logic                     invert_i,
  output logic                     req_valid_o,
  output usqt_pkg::vreq_t          req_o
);
  import usqt_pkg::*;

  logic               busy_q;
  logic [VtxCntW-1:0] cnt_q;
  logic [CellW-1:0]   i_q, j_q;
  logic [SliceW-1:0]  nx_q, ny_q;
  logic               neg_q;
  logic [SliceW-1:0]  nx_d, ny_d;
  logic [CellW-1:0]   i_d, j_d;
  logic               accept;
  logic [1:0]         code;

  assign nx_d = eff_slices(x_slices_i);
  assign ny_d = eff_slices(y_slices_i);
  assign i_d  = ({1'b0, cell_lon_i} >= nx_d) ? CellW'(nx_d - SliceW'(1)) : cell_lon_i;
  assign j_d  = ({1'b0, cell_lat_i} >= ny_d) ? CellW'(ny_d - SliceW'(1)) : cell_lat_i;

  assign cell_ready_o = en_i && (!busy_q || cnt_q == LastVtx);
  assign accept       = cell_valid_i && cell_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (en_i && busy_q) begin
      if (cnt_q == LastVtx) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + VtxCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      i_q   <= i_d;
      j_q   <= j_d;
      nx_q  <= nx_d;
      ny_q  <= ny_d;
      neg_q <= invert_i;
    end
  end

  assign code        = corner_code(neg_q, cnt_q);
  assign req_valid_o = busy_q;

  always_comb begin
    req_o.p    = {1'b0, i_q} + SliceW'(code[0]);
    req_o.q    = {1'b0, j_q} + SliceW'(code[1]);
    req_o.nx   = nx_q;
    req_o.ny   = ny_q;
    req_o.neg  = neg_q;
    req_o.last = (cnt_q == LastVtx);
  end

endmodule

/* rtl/usqt_div.sv */
// Pipelined radix-2 divider: turns corner indices into angle phases and
// rounded texture coordinates, eight quotient bits per stage. Depends on usqt_pkg.
module usqt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              req_valid_i,
  input  usqt_pkg::vreq_t   req_i,
  output logic              ph_valid_o,
  output usqt_pkg::phase_t  ph_o
);
  import usqt_pkg::*;

  typedef struct packed {
    logic [SliceW-1:0] rem_a;
    logic [SliceW-1:0] rem_b;
    logic [PhaseW:0]   qa;
    logic [PhaseW:0]   qb;
    logic [SliceW-1:0] nx;
    logic [SliceW-1:0] ny;
    logic [TexW-1:0]   tex_u;
    logic [TexW-1:0]   tex_v;
    logic              neg;
    logic              last;
  } dstate_t;

  // One restoring step on both lanes. After the fourteenth step the quotient
  // is the texture coordinate before rounding; the remainder decides rounding.
  function automatic dstate_t div_step(dstate_t d, int k);
    dstate_t         r;
    logic [SliceW:0] ra, rb;
    logic            rnd_a, rnd_b;
    r  = d;
    ra = {d.rem_a, 1'b0};
    rb = {d.rem_b, 1'b0};
    if (ra >= {1'b0, d.nx}) begin
      r.rem_a = SliceW'(ra - {1'b0, d.nx});
      r.qa    = {d.qa[PhaseW-1:0], 1'b1};
    end else begin
      r.rem_a = ra[SliceW-1:0];
      r.qa    = {d.qa[PhaseW-1:0], 1'b0};
    end
    if (rb >= {1'b0, d.ny}) begin
      r.rem_b = SliceW'(rb - {1'b0, d.ny});
      r.qb    = {d.qb[PhaseW-1:0], 1'b1};
    end else begin
      r.rem_b = rb[SliceW-1:0];
      r.qb    = {d.qb[PhaseW-1:0], 1'b0};
    end
    if (k == FracBits - 1) begin
      rnd_a   = (({1'b0, r.rem_a} + {2'b0, d.nx[SliceW-1:1]}) >= {1'b0, d.nx});
      rnd_b   = (({1'b0, r.rem_b} + {2'b0, d.ny[SliceW-1:1]}) >= {1'b0, d.ny});
      r.tex_u = r.qa[TexW-1:0] + TexW'(rnd_a);
      r.tex_v = TexOne - (r.qb[TexW-1:0] + TexW'(rnd_b));
    end
    return r;
  endfunction

  dstate_t                init_d;
  dstate_t                st_q [DivStages];
  logic [DivStages-1:0]   vld_q;
  logic                   a_int, b_int;

  // Index = slice count: integer bit set, remainder zero; whole turn, half on latitude.
  assign a_int = (req_i.p == req_i.nx);
  assign b_int = (req_i.q == req_i.ny);

  always_comb begin
    init_d       = '0;
    init_d.rem_a = a_int ? '0 : req_i.p;
    init_d.rem_b = b_int ? '0 : req_i.q;
    init_d.qa    = {{PhaseW{1'b0}}, a_int};
    init_d.qb    = {{PhaseW{1'b0}}, b_int};
    init_d.nx    = req_i.nx;
    init_d.ny    = req_i.ny;
    init_d.neg   = req_i.neg;
    init_d.last  = req_i.last;
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    dstate_t cur, nxt;
    logic    vin;
    if (s == 0) begin : g_first
      assign cur = init_d;
      assign vin = req_valid_i;
    end else begin : g_next
      assign cur = st_q[s-1];
      assign vin = vld_q[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int t = 0; t < DivPerStage; t++) begin
        nxt = div_step(nxt, s * DivPerStage + t);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= nxt;
      end
    end
  end

  assign ph_valid_o = vld_q[DivStages-1];

  always_comb begin
    ph_o.pha        = st_q[DivStages-1].qa[PhaseW-1:0];
    ph_o.phb        = st_q[DivStages-1].qb[PhaseW:1];
    ph_o.side.tex_u = st_q[DivStages-1].tex_u;
    ph_o.side.tex_v = st_q[DivStages-1].tex_v;
    ph_o.side.neg   = st_q[DivStages-1].neg;
    ph_o.side.last  = st_q[DivStages-1].last;
  end

endmodule

/* rtl/usqt_sincos.sv */
// Dual-lane sine/cosine pipeline: phase scaling multiply, twenty CORDIC
// rotations at two per stage, then quadrant fold. Depends on usqt_pkg.
module usqt_sincos (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              ph_valid_i,
  input  usqt_pkg::phase_t  ph_i,
  output logic              trig_valid_o,
  output usqt_pkg::trig_t   trig_o
);
  import usqt_pkg::*;

  typedef struct packed {
    logic signed [AngW-1:0] x;
    logic signed [AngW-1:0] y;
    logic signed [AngW-1:0] z;
  } rot_t;

  typedef struct packed {
    rot_t       a;
    rot_t       b;
    logic [1:0] qa;
    logic [1:0] qb;
    side_t      side;
  } cstate_t;

  localparam logic [1:0] QuadI   = 2'd0;
  localparam logic [1:0] QuadII  = 2'd1;
  localparam logic [1:0] QuadIII = 2'd2;

  function automatic rot_t rot_step(rot_t r, int k);
    rot_t                   o;
    logic signed [AngW-1:0] xs, ys;
    xs = r.x >>> k;
    ys = r.y >>> k;
    if (!r.z[AngW-1]) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - atan_q30(k);
    end else begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + atan_q30(k);
    end
    return o;
  endfunction

  function automatic void quad_fold(input rot_t r, input logic [1:0] q,
                                    output logic signed [AngW-1:0] s,
                                    output logic signed [AngW-1:0] c);
    case (q)
      QuadI:   begin s = r.y;  c = r.x;  end
      QuadII:  begin s = r.x;  c = -r.y; end
      QuadIII: begin s = -r.y; c = -r.x; end
      default: begin s = -r.x; c = r.y;  end
    endcase
  endfunction

  logic [60:0]             prod_a, prod_b;
  cstate_t                 m_d, m_q;
  logic                    m_vld_q;
  cstate_t                 cs_q [CordicStages];
  logic [CordicStages-1:0] cs_vld_q;
  trig_t                   trig_d, trig_q;
  logic                    trig_vld_q;

  // Residual angle in Q30 radians: low 30 phase bits times pi/2.
  assign prod_a = 61'(ph_i.pha[29:0]) * 61'(HalfPiQ30);
  assign prod_b = 61'(ph_i.phb[29:0]) * 61'(HalfPiQ30);

  always_comb begin
    m_d.a.x  = CordicStart;
    m_d.a.y  = '0;
    m_d.a.z  = {2'b00, prod_a[60:30]};
    m_d.b.x  = CordicStart;
    m_d.b.y  = '0;
    m_d.b.z  = {2'b00, prod_b[60:30]};
    m_d.qa   = ph_i.pha[PhaseW-1:PhaseW-2];
    m_d.qb   = ph_i.phb[PhaseW-1:PhaseW-2];
    m_d.side = ph_i.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q    <= 1'b0;
      trig_vld_q <= 1'b0;
    end else if (en_i) begin
      m_vld_q    <= ph_valid_i;
      trig_vld_q <= cs_vld_q[CordicStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      trig_q <= trig_d;
    end
  end

  for (genvar s = 0; s < CordicStages; s++) begin : g_stage
    cstate_t cur, nxt;
    logic    vin;
    if (s == 0) begin : g_first
      assign cur = m_q;
      assign vin = m_vld_q;
    end else begin : g_next
      assign cur = cs_q[s-1];
      assign vin = cs_vld_q[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int t = 0; t < CordicPerStage; t++) begin
        nxt.a = rot_step(nxt.a, s * CordicPerStage + t);
        nxt.b = rot_step(nxt.b, s * CordicPerStage + t);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cs_vld_q[s] <= 1'b0;
      end else if (en_i) begin
        cs_vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cs_q[s] <= nxt;
      end
    end
  end

  always_comb begin
    quad_fold(cs_q[CordicStages-1].a, cs_q[CordicStages-1].qa, trig_d.sa, trig_d.ca);
    quad_fold(cs_q[CordicStages-1].b, cs_q[CordicStages-1].qb, trig_d.sb, trig_d.cb);
    trig_d.side = cs_q[CordicStages-1].side;
  end

  assign trig_valid_o = trig_vld_q;
  assign trig_o       = trig_q;

endmodule

/* rtl/uv_sphere_quad_tessellator.sv */
// Top level of the UV sphere quad tessellator: configuration registers,
// sequencer, divider, sine/cosine pipeline, product and output stages.
// Depends on usqt_pkg, usqt_seq, usqt_div and usqt_sincos.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata: cell_lon, cell_lat
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata: vertex fields, tlast
//   cfg       in         cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// A cell is taken while the sequencer is idle or issuing its sixth vertex and
// yields one vertex a cycle while the output is not stalled; the first vertex
// of a cell passes the sequencer register, 4 divider stages, 12 sine/cosine
// stages, product and output registers. The six-vertex sequencer sets the cell
// rate. Reset clears valid bits and sets the registers to 16, 16 and 0. When
// the output is stalled the whole pipeline holds; nothing is dropped or repeated.
module uv_sphere_quad_tessellator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [usqt_pkg::InDataW-1:0]  s_axis_tdata,  // cell_lon, cell_lat
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, nrm_x, nrm_y, nrm_z, two zero bits
  output logic [usqt_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,  // last_vertex
  input  logic                          cfg_we_i,
  input  logic [usqt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [usqt_pkg::SliceW-1:0]   cfg_data_i
);
  import usqt_pkg::*;

  typedef struct packed {
    logic signed [ProdW-1:0] px;
    logic signed [ProdW-1:0] py;
    logic signed [ProdW-1:0] pz;
    side_t                   side;
  } prod_t;

  function automatic logic signed [PosW-1:0] rnd_sat(logic signed [ProdW-1:0] v, int k);
    logic signed [ProdW-1:0] sh;
    sh = (v + (ProdW'(1) <<< (k - 1))) >>> k;
    if (sh > $signed(ProdW'(2 ** (PosW - 1) - 1))) begin
      return {1'b0, {(PosW-1){1'b1}}};
    end else if (sh < -$signed(ProdW'(2 ** (PosW - 1)))) begin
      return {1'b1, {(PosW-1){1'b0}}};
    end
    return sh[PosW-1:0];
  endfunction

  function automatic logic signed [PosW-1:0] neg_sat(logic signed [PosW-1:0] v);
    if (v == {1'b1, {(PosW-1){1'b0}}}) begin
      return {1'b0, {(PosW-1){1'b1}}};
    end
    return -v;
  endfunction

  logic [SliceW-1:0] x_slices_q, y_slices_q;
  logic              invert_q;
  logic              en;
  logic              req_valid, ph_valid, trig_valid;
  vreq_t             req;
  phase_t            ph;
  trig_t             trig;
  prod_t             prod_d, prod_q;
  logic              prod_vld_q;
  logic signed [PosW-1:0] pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z;
  logic [OutDataW-1:0]    out_data_q;
  logic                   out_last_q, out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_slices_q <= SliceReset;
      y_slices_q <= SliceReset;
      invert_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_SLICES: x_slices_q <= cfg_data_i;
        CFG_Y_SLICES: y_slices_q <= cfg_data_i;
        CFG_INVERT:   invert_q   <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  assign en = !out_vld_q || m_axis_tready;

  usqt_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .cell_valid_i (s_axis_tvalid),
    .cell_ready_o (s_axis_tready),
    .cell_lon_i   (s_axis_tdata[CellW-1:0]),
    .cell_lat_i   (s_axis_tdata[2*CellW-1:CellW]),
    .x_slices_i   (x_slices_q),
    .y_slices_i   (y_slices_q),
    .invert_i     (invert_q),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  usqt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .req_valid_i (req_valid),
    .req_i       (req),
    .ph_valid_o  (ph_valid),
    .ph_o        (ph)
  );

  usqt_sincos u_sincos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ph_valid_i   (ph_valid),
    .ph_i         (ph),
    .trig_valid_o (trig_valid),
    .trig_o       (trig)
  );

  always_comb begin
    prod_d.px   = trig.sb * trig.sa;
    prod_d.pz   = trig.sb * trig.ca;
    prod_d.py   = ProdW'(trig.cb);
    prod_d.side = trig.side;
  end

  // Products are Q60, the latitude cosine Q30.
  assign pos_x = rnd_sat(prod_q.px, 60 - FracBits);
  assign pos_y = rnd_sat(prod_q.py, 30 - FracBits);
  assign pos_z = rnd_sat(prod_q.pz, 60 - FracBits);
  assign nrm_x = prod_q.side.neg ? neg_sat(pos_x) : pos_x;
  assign nrm_y = prod_q.side.neg ? neg_sat(pos_y) : pos_y;
  assign nrm_z = prod_q.side.neg ? neg_sat(pos_z) : pos_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      prod_vld_q <= trig_valid;
      out_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q     <= prod_d;
      out_data_q <= {2'b00, nrm_z, nrm_y, nrm_x, prod_q.side.tex_v,
                     prod_q.side.tex_u, pos_z, pos_y, pos_x};
      out_last_q <= prod_q.side.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/usqt_checker.sv */
// Port-level checks of the UV sphere quad tessellator, bound to the top level.
// Depends on uv_sphere_quad_tessellator port names.
module usqt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [15:0]  s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         cfg_we_i,
  input logic [1:0]   cfg_idx_i,
  input logic [8:0]   cfg_data_i
);

  // A stalled vertex holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("stalled vertex changed");

  // A cell occupies the sequencer until its six corner requests are issued, so no back-to-back accept.
  a_cell_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("cell accepted in consecutive cycles");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[62:48] <= 15'd16384 && m_axis_tdata[77:63] <= 15'd16384)
    else $error("texture coordinate above one");

  // The normal is the position or its saturated negation.
  a_nrm_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[93:78] == m_axis_tdata[15:0]
      || m_axis_tdata[93:78] == 16'(-m_axis_tdata[15:0])
      || (m_axis_tdata[15:0] == 16'h8000 && m_axis_tdata[93:78] == 16'h7fff))
    else $error("normal x does not follow position x");

endmodule

bind uv_sphere_quad_tessellator usqt_checker u_usqt_checker (.*);

/* sim/tb_uv_sphere_quad_tessellator.sv */
// Self-checking testbench for the UV sphere quad tessellator.
// Computes every expected vertex in a scoreboard class and compares it with the
// stream output; depends on usqt_pkg and the uv_sphere_quad_tessellator RTL.
module tb_uv_sphere_quad_tessellator;
  timeunit 1ns;
  timeprecision 1ps;
  import usqt_pkg::*;

  // Members run from the highest tdata field down, so the packed layout
  // matches {m_axis_tdata[125:0], m_axis_tlast}.
  typedef struct packed {
    logic [15:0] nrm_z, nrm_y, nrm_x;
    logic [14:0] tex_v, tex_u;
    logic [15:0] pos_z, pos_y, pos_x;
    logic        last;
  } vertex_t;

  class vertex_scoreboard;
    logic [SliceW-1:0] x_slices = 9'd16;
    logic [SliceW-1:0] y_slices = 9'd16;
    bit                invert   = 1'b0;
    vertex_t           pending[$];
    int                mismatches = 0;

    function automatic longint asr(longint v, int k);
      return v >>> k;
    endfunction

    function automatic longint atan_tab(int k);
      longint t[20] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF};
      return t[k];
    endfunction

    // Quadrant split, CORDIC on the residual, then quadrant fix-up.
    function automatic void sin_cos(logic [31:0] ph, output longint s,
                                    output longint c);
      longint x, y, z, xs, ys;
      logic [63:0] res;
      res = {34'd0, ph[29:0]} * 64'h6487ED51;
      z = longint'(res >> 30);
      x = 64'h26DD3B6A;
      y = 0;
      for (int k = 0; k < 20; k++) begin
        xs = asr(x, k);
        ys = asr(y, k);
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - atan_tab(k);
        end else begin
          x = x + ys; y = y - xs; z = z + atan_tab(k);
        end
      end
      case (ph[31:30])
        2'd0: begin s = y; c = x; end
        2'd1: begin s = x; c = -y; end
        2'd2: begin s = -y; c = -x; end
        default: begin s = -x; c = y; end
      endcase
    endfunction

    function automatic longint rsat(longint v, int k);
      longint r;
      r = (v + (longint'(1) << (k - 1))) >>> k;
      return r < -32768 ? -32768 : (r > 32767 ? 32767 : r);
    endfunction

    function automatic longint clamp_neg(longint v);
      return -v > 32767 ? 32767 : -v;
    endfunction

    function automatic vertex_t corner(int p, int q, int nx, int ny, bit neg, bit last);
      vertex_t r;
      longint sa, ca, sb, cb, px, py, pz, u, v;
      logic [63:0] pha, phb;
      pha = (64'(p) << 32) / nx;
      phb = (64'(q) << 31) / ny;
      sin_cos(pha[31:0], sa, ca);
      sin_cos(phb[31:0], sb, cb);
      px = rsat(sb * sa, 60 - FracBits);
      py = rsat(cb, 30 - FracBits);
      pz = rsat(sb * ca, 60 - FracBits);
      u = ((longint'(p) << FracBits) + nx / 2) / nx;
      v = (longint'(1) << FracBits) - ((longint'(q) << FracBits) + ny / 2) / ny;
      r.pos_x = px[15:0]; r.pos_y = py[15:0]; r.pos_z = pz[15:0];
      r.tex_u = u < 0 ? 15'd0 : (u > 32767 ? 15'h7FFF : u[14:0]);
      r.tex_v = v < 0 ? 15'd0 : (v > 32767 ? 15'h7FFF : v[14:0]);
      if (neg) begin
        px = clamp_neg(px); py = clamp_neg(py); pz = clamp_neg(pz);
      end
      r.nrm_x = px[15:0]; r.nrm_y = py[15:0]; r.nrm_z = pz[15:0];
      r.last = last;
      return r;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [SliceW-1:0] val);
      case (idx)
        CFG_X_SLICES: x_slices = val;
        CFG_Y_SLICES: y_slices = val;
        CFG_INVERT:   invert = val[0];
        default: ;
      endcase
    endfunction

    function void note_cell(logic [7:0] lon, logic [7:0] lat);
      int nx, ny, i, j;
      logic [1:0] c;
      vertex_t vtx;
      nx = x_slices == 0 ? 1 : (x_slices > MaxSlices ? MaxSlices : x_slices);
      ny = y_slices == 0 ? 1 : (y_slices > MaxSlices ? MaxSlices : y_slices);
      i = lon >= nx ? nx - 1 : lon;
      j = lat >= ny ? ny - 1 : lat;
      for (int k = 0; k < 6; k++) begin
        c = corner_order(invert, k);
        vtx = corner(i + c[0], j + c[1], nx, ny, invert, k == 5);
        pending.insert(pending.size(), vtx);
      end
    endfunction

    function automatic logic [1:0] corner_order(bit neg, int k);
      logic [1:0] fwd[6] = '{2'd0, 2'd2, 2'd1, 2'd2, 2'd3, 2'd1};
      logic [1:0] inv[6] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd3};
      return neg ? inv[k] : fwd[k];
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected vertex %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Vertex mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // cell_lon, cell_lat
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;       // vertex fields, two zero bits
  logic                m_axis_tlast;       // last_vertex
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [SliceW-1:0]   cfg_data_i = '0;

  vertex_scoreboard board = new();
  int  idle_pct = 34;
  bit  done = 1'b0;

  uv_sphere_quad_tessellator u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= $urandom_range(99) >= idle_pct;
    if (m_axis_tvalid && m_axis_tready)
      board.check_vertex({m_axis_tdata[125:0], m_axis_tlast});
  end

  // The valid flag stays high from one item to the next unless an idle cycle
  // is drawn, so every cycle sees at most one update of it.
  task automatic send_cell(logic [7:0] lon, logic [7:0] lat);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lat, lon};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_cell(lon, lat);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SliceW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(logic [SliceW-1:0] nx, logic [SliceW-1:0] ny, bit inv);
    drain();
    write_reg(CFG_X_SLICES, nx);
    write_reg(CFG_Y_SLICES, ny);
    write_reg(CFG_INVERT, {8'd0, inv});
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset shape first, corners and clamped indices included.
    send_cell(8'd0, 8'd0);
    send_cell(8'd15, 8'd15);
    send_cell(8'd255, 8'd255);
    send_cell(8'd7, 8'd3);
    set_shape(9'd0, 9'd0, 1'b1);
    send_cell(8'd0, 8'd0);
    send_cell(8'd200, 8'd9);
    set_shape(9'd511, 9'd300, 1'b0);
    send_cell(8'd255, 8'd255);
    send_cell(8'd0, 8'd128);
    send_cell(8'hAA, 8'h55);
    set_shape(9'd256, 9'd256, 1'b1);
    send_cell(8'd255, 8'd0);
    send_cell(8'h55, 8'hAA);
    set_shape(9'd1, 9'd2, 1'b0);
    send_cell(8'd0, 8'd1);
    send_cell(8'd3, 8'd0);
    // Random phases; the second has no idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      set_shape(9'($urandom_range(ph == 5 ? 511 : 40)), 9'($urandom_range(40)),
                $urandom_range(1));
      idle_pct = ph == 1 ? 0 : 34;
      for (int n = 0; n < 17; n++) begin
        send_cell(8'($urandom), 8'($urandom));
        if (ph == 3 && n == 8) drain();
      end
    end
    drain();
    done = 1'b1;
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    if (!done) $display("Simulation FAILED");
    $finish;
  end
endmodule
